>>> hdl/imgconv_pkg.sv
package imgconv_pkg;

  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_FRAC_BITS = 12;
  localparam int KERNEL_SIZE   = 3;
  localparam int CHANNELS      = 3;
  localparam int MAX_HEIGHT    = 1024;
  localparam int CFG_W         = 48;
  localparam int PIX_W         = 8 * CHANNELS;

  localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_CHANNEL_COUNT = 3'd2;
  localparam logic [2:0] REG_COEF_TOP      = 3'd3;
  localparam logic [2:0] REG_COEF_MIDDLE   = 3'd4;
  localparam logic [2:0] REG_COEF_BOTTOM   = 3'd5;

  localparam logic [10:0]      RST_IMAGE_WIDTH   = 11'd1024;
  localparam logic [10:0]      RST_IMAGE_HEIGHT  = 11'd1024;
  localparam logic [1:0]       RST_CHANNEL_COUNT = 2'd3;
  localparam logic [CFG_W-1:0] RST_COEF_TOP      = 48'h0000_0000_0000;
  localparam logic [CFG_W-1:0] RST_COEF_MIDDLE   = 48'h0000_1000_0000;
  localparam logic [CFG_W-1:0] RST_COEF_BOTTOM   = 48'h0000_0000_0000;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [KERNEL_SIZE-1:0] col_t;
  typedef logic signed [15:0] tap_t;

  function automatic tap_t tap_of(input logic [CFG_W-1:0] taps, input int slot);
    tap_of = tap_t'(taps[16*slot +: 16]);
  endfunction

endpackage

>>> hdl/image_convolution_3x3_top.sv
// 3x3 convolution with zero padding over a raster pixel stream of up to three 8-bit
// channels, taps signed Q4.12 per row in 16-bit slots (left, centre, right). One beat is
// accepted per clock while item_stall is low; a single-port-per-side line store of
// MAX_WIDTH words holds the two prior rows; it is read in the accept cycle and written
// back in the cycle after, with forwarding when consecutive beats hit the same column
// (image width one). The beat that completes a window passes through the pipeline
// registers into the queue; that beat trails the pixel by one row plus one pixel, so
// image_width + 1 flush beats after the frame drain the last results. Results wait in an
// eight-entry queue and item_stall rises only when eight beats are in flight or queued.
// Line store words hold nothing defined until the first frame has written them; there
// is no clearing pass. Registers may be written only while no beat is in flight.
module image_convolution_3x3_top
  import imgconv_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_en,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             item_valid,
  output logic             item_stall,
  input  logic             kind,
  input  logic [7:0]       chan0_in,
  input  logic [7:0]       chan1_in,
  input  logic [7:0]       chan2_in,
  output logic             result_valid,
  input  logic             result_stall,
  output logic [7:0]       chan0_out,
  output logic [7:0]       chan1_out,
  output logic [7:0]       chan2_out,
  output logic             last_of_frame
);

  localparam int CW         = $clog2(MAX_WIDTH);
  localparam int GW         = (CW > 11) ? CW + 1 : 12;
  localparam int PROD_W     = 25;
  localparam int ROW_W      = 27;
  localparam int SUM_W      = 29;
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int RES_W      = PIX_W + 1;
  localparam logic [GW-1:0]  W_CAP   = GW'(MAX_WIDTH);
  localparam logic [GW-1:0]  H_CAP   = GW'(MAX_HEIGHT);
  localparam logic [PTR_W:0] Q_LIMIT = (PTR_W + 1)'(FIFO_DEPTH);

  // configuration
  logic [10:0]      image_width;
  logic [10:0]      image_height;
  logic [1:0]       channel_count;
  logic [CFG_W-1:0] coef_top;
  logic [CFG_W-1:0] coef_middle;
  logic [CFG_W-1:0] coef_bottom;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= RST_IMAGE_WIDTH;
      image_height  <= RST_IMAGE_HEIGHT;
      channel_count <= RST_CHANNEL_COUNT;
      coef_top      <= RST_COEF_TOP;
      coef_middle   <= RST_COEF_MIDDLE;
      coef_bottom   <= RST_COEF_BOTTOM;
    end else if (cfg_en) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:   image_width   <= cfg_data[10:0];
        REG_IMAGE_HEIGHT:  image_height  <= cfg_data[10:0];
        REG_CHANNEL_COUNT: channel_count <= cfg_data[1:0];
        REG_COEF_TOP:      coef_top      <= cfg_data;
        REG_COEF_MIDDLE:   coef_middle   <= cfg_data;
        REG_COEF_BOTTOM:   coef_bottom   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [GW-1:0] w_eff;
  logic [GW-1:0] h_eff;

  always_comb begin
    if (image_width == '0) begin
      w_eff = GW'(1);
    end else if (GW'(image_width) > W_CAP) begin
      w_eff = W_CAP;
    end else begin
      w_eff = GW'(image_width);
    end
    if (image_height == '0) begin
      h_eff = GW'(1);
    end else if (GW'(image_height) > H_CAP) begin
      h_eff = H_CAP;
    end else begin
      h_eff = GW'(image_height);
    end
  end

  // accept and position counters
  logic          acc;
  logic [CW-1:0] in_column;
  logic [CW-1:0] in_column_next;
  logic [10:0]   in_row;
  logic [10:0]   in_row_next;
  logic [GW-1:0] xg;
  logic [GW-1:0] yg;
  logic          col_zero;
  logic          emit_a;
  logic          last_a;
  logic [PIX_W-1:0] pix_a;

  assign acc = item_valid && !item_stall;
  assign xg  = GW'(in_column);
  assign yg  = GW'(in_row);
  assign col_zero = (in_column == '0);

  always_comb begin
    if (!kind && (yg < h_eff)) begin
      pix_a = {chan2_in, chan1_in, chan0_in};
    end else begin
      pix_a = '0;
    end
    if (col_zero) begin
      emit_a = (yg >= GW'(2)) && (yg <= h_eff + GW'(1));
      last_a = (yg == h_eff + GW'(1));
    end else begin
      emit_a = (yg >= GW'(1)) && (yg <= h_eff);
      last_a = (yg == h_eff) && (xg == w_eff);
    end
    if (yg >= h_eff + GW'(1)) begin
      in_column_next = '0;
      in_row_next    = '0;
    end else if (xg + GW'(1) >= w_eff) begin
      in_column_next = '0;
      in_row_next    = in_row + 11'd1;
    end else begin
      in_column_next = in_column + CW'(1);
      in_row_next    = in_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column <= '0;
      in_row    <= '0;
    end else if (acc) begin
      in_column <= in_column_next;
      in_row    <= in_row_next;
    end
  end

  // line store read-modify-write
  logic [2*PIX_W-1:0] row_store [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q;
  logic [2*PIX_W-1:0] fwd1;
  logic [2*PIX_W-1:0] stored;
  logic [2*PIX_W-1:0] wr_word;
  logic               v1;
  logic               f1;
  logic [CW-1:0]      x1;
  logic               up1_ok1;
  logic               up2_ok1;
  logic               zero1;
  logic               e1;
  logic               l1;
  logic [PIX_W-1:0]   pix1;
  pix_t               up1;
  pix_t               up2;

  assign stored  = f1 ? fwd1 : rd_q;
  assign up1     = up1_ok1 ? stored[PIX_W-1:0] : '0;
  assign up2     = up2_ok1 ? stored[2*PIX_W-1:PIX_W] : '0;
  assign wr_word = {up1, pix1};

  always_ff @(posedge clk) begin
    if (acc) begin
      rd_q <= row_store[in_column];
    end
    if (v1) begin
      row_store[x1] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      f1      <= v1 && (x1 == in_column);
      fwd1    <= wr_word;
      x1      <= in_column;
      up1_ok1 <= (in_row != '0);
      up2_ok1 <= (in_row >= 11'd2);
      zero1   <= col_zero;
      e1      <= emit_a;
      l1      <= last_a;
      pix1    <= pix_a;
    end
  end

  // window shift
  col_t win [KERNEL_SIZE];
  col_t win_next [KERNEL_SIZE];
  col_t calc [KERNEL_SIZE];
  col_t new_col;

  always_comb begin
    new_col[0] = up2;
    new_col[1] = up1;
    new_col[2] = pix1;
    if (zero1) begin
      for (int c = 0; c < KERNEL_SIZE - 1; c++) begin
        calc[c]     = win[c+1];
        win_next[c] = '0;
      end
      calc[KERNEL_SIZE-1]     = '0;
      win_next[KERNEL_SIZE-1] = new_col;
    end else begin
      for (int c = 0; c < KERNEL_SIZE - 1; c++) begin
        win_next[c] = win[c+1];
      end
      win_next[KERNEL_SIZE-1] = new_col;
      calc = win_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < KERNEL_SIZE; c++) begin
        win[c] <= '0;
      end
    end else if (v1) begin
      win <= win_next;
    end
  end

  // multiply, row sums, final sum
  logic v2, v3, v4;
  logic e2, e3, e4;
  logic l2, l3, l4;
  col_t calc2 [KERNEL_SIZE];
  logic signed [PROD_W-1:0] prod3 [CHANNELS][KERNEL_SIZE][KERNEL_SIZE];
  logic signed [ROW_W-1:0]  row4 [CHANNELS][KERNEL_SIZE];
  logic [CFG_W-1:0]         coef_row [KERNEL_SIZE];

  assign coef_row[0] = coef_top;
  assign coef_row[1] = coef_middle;
  assign coef_row[2] = coef_bottom;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    e2    <= e1;
    l2    <= l1;
    e3    <= e2;
    l3    <= l2;
    e4    <= e3;
    l4    <= l3;
    calc2 <= calc;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      for (int r = 0; r < KERNEL_SIZE; r++) begin
        for (int c = 0; c < KERNEL_SIZE; c++) begin
          prod3[ch][r][c] <= PROD_W'(tap_of(coef_row[r], c))
                             * PROD_W'($signed({1'b0, calc2[c][r][8*ch +: 8]}));
        end
        row4[ch][r] <= ROW_W'(prod3[ch][r][0]) + ROW_W'(prod3[ch][r][1])
                       + ROW_W'(prod3[ch][r][2]);
      end
    end
  end

  logic signed [SUM_W-1:0] sum4 [CHANNELS];
  logic [SUM_W-1:0]        mag4 [CHANNELS];
  logic [PIX_W-1:0]        bytes4;

  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      sum4[ch] = SUM_W'(row4[ch][0]) + SUM_W'(row4[ch][1]) + SUM_W'(row4[ch][2]);
      mag4[ch] = (sum4[ch] < 0) ? SUM_W'(-sum4[ch]) : SUM_W'(sum4[ch]);
      if (2'(ch) < channel_count) begin
        bytes4[8*ch +: 8] = 8'(mag4[ch] >> FRAC_BITS);
      end else begin
        bytes4[8*ch +: 8] = '0;
      end
    end
  end

  // result queue and credit count
  logic [RES_W-1:0] res_q [FIFO_DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [PTR_W:0]   fcount;
  logic [PTR_W:0]   occ;
  logic             push;
  logic             pop;
  logic             drop;

  assign push = v4 && e4;
  assign drop = v4 && !e4;
  assign pop  = result_valid && !result_stall;

  assign result_valid = (fcount != '0);
  assign item_stall   = (occ == Q_LIMIT);
  assign {last_of_frame, chan2_out, chan1_out, chan0_out} = res_q[head];

  always_ff @(posedge clk) begin
    if (push) begin
      res_q[tail] <= {l4, bytes4};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      tail   <= '0;
      fcount <= '0;
      occ    <= '0;
    end else begin
      if (push) begin
        tail <= tail + PTR_W'(1);
      end
      if (pop) begin
        head <= head + PTR_W'(1);
      end
      fcount <= fcount + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
      occ    <= occ + (PTR_W + 1)'(acc) - (PTR_W + 1)'(pop) - (PTR_W + 1)'(drop);
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst) occ <= Q_LIMIT)
    else $error("credit count above queue depth");

  a_queue_in_credit: assert property (@(posedge clk) disable iff (rst) fcount <= occ)
    else $error("queued results not covered by credits");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (fcount < Q_LIMIT) || pop)
    else $error("result queue overflow");

endmodule
